@@ rtl/core/lned_pkg.sv @@
// ============================================================================
// lned_pkg - shared definitions for the leet-normalized edit distance matcher
// Register indexes, fixed field widths, similarity scale and the character
// classification helpers used by the matcher.
// ============================================================================
`default_nettype none

package lned_pkg;

    // Default for the longest reference word the DP row can hold
    localparam int DEF_MAX_REF_LEN = 16;

    // Reference bytes carried by the two 64-bit config registers
    localparam int REF_BYTES = 16;

    // Similarity is a percent with 8 fraction bits: 100 * 256
    localparam int SIM_SCALE = 25600;

    // 25600 * 255 fits in 23 bits; the quotient never exceeds 25600
    localparam int NUM_W     = 23;
    localparam int QUO_W     = 15;
    localparam int DIV_CNT_W = 4;

    // Config port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REF_LOW  = 2'd0,
        CFG_REF_HIGH = 2'd1,
        CFG_REF_LEN  = 2'd2,
        CFG_MAX_DIST = 2'd3
    } cfg_reg_t;

    // Leet symbols become letters; everything else passes unchanged
    function automatic logic [7:0] normalize_char(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            8'h31:   r = 8'h69;  // '1' -> 'i'
            8'h30:   r = 8'h6F;  // '0' -> 'o'
            8'h33:   r = 8'h65;  // '3' -> 'e'
            8'h34:   r = 8'h61;  // '4' -> 'a'
            8'h35:   r = 8'h73;  // '5' -> 's'
            8'h37:   r = 8'h74;  // '7' -> 't'
            8'h40:   r = 8'h61;  // '@' -> 'a'
            8'h24:   r = 8'h73;  // '$' -> 's'
            8'h21:   r = 8'h69;  // '!' -> 'i'
            default: r = c;
        endcase
        return r;
    endfunction

    // Blank, tab, LF, VT, FF, CR
    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h61) && (c <= 8'h7A)) ||
               ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/leet_normalized_edit_distance_matcher.sv @@
// ============================================================================
// leet_normalized_edit_distance_matcher - word matcher on normalized text
// Normalizes raw message bytes, splits them into words and scores each word
// against a configured reference word by Levenshtein distance.
// ============================================================================
//
// Usage:
//   s_* carries one message byte per item (tdata = msg_byte, tlast = end of
//   message). m_* carries one result per matching word. cfg_* writes the
//   reference bytes, reference length and distance threshold; write it only
//   while no item is in flight.
// Operation:
//   a dropped or blank byte without a word to close goes straight to finish
//   letter or digit: one DP cell per cycle through the shared cell unit and
//   the row memory, which has one read port and one write port
//   closing a word reads the last cell and tests it; a matching word then
//   takes one multiply and the one-bit-per-cycle restoring divider
//   A result appears on m_* in the cycle after the sequencer emits it.
// s_tready is high only while the sequencer is idle.
// The result sits in an output register; the next item is taken while it
// waits. A further result waits in the sequencer until that register frees.
// Reset: config returns to defaults (threshold 1), word state clears and all
// row-valid flags clear at once, so there is no clearing pass.

`default_nettype none

module leet_normalized_edit_distance_matcher
    import lned_pkg::*;
#(
    parameter int MAX_REF_LEN = DEF_MAX_REF_LEN
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // Input bytes
    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] msg_byte
    input  wire logic                  s_tlast,   // end_of_message

    // Results
    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    output      logic [47:0]           m_tdata,   // [7:0] distance, [22:8] similarity,
                                                  // [30:23] word_length,
                                                  // [46:31] word_index, [47] zero
    output      logic                  m_tuser,   // [0] saturated

    // Config writes
    input  wire logic                  cfg_valid,
    output      logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int COL_W  = $clog2(MAX_REF_LEN + 1);
    localparam int ADDR_W = (MAX_REF_LEN > 1) ? $clog2(MAX_REF_LEN) : 1;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_PREP     = 9'b000000010,
        ST_CELL     = 9'b000000100,
        ST_CLOSE_RD = 9'b000001000,
        ST_CLOSE_D  = 9'b000010000,
        ST_MUL      = 9'b000100000,
        ST_DIV      = 9'b001000000,
        ST_EMIT     = 9'b010000000,
        ST_FINISH   = 9'b100000000
    } state_t;

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    logic [63:0]            ref_low_reg;
    logic [63:0]            ref_high_reg;
    logic [4:0]             ref_len_reg;
    logic [7:0]             max_dist_reg;

    state_t                 state_reg, state_next;
    logic [7:0]             char_reg, char_next;
    logic                   eom_reg, eom_next;
    logic                   close_reg, close_next;
    logic                   inside_reg, inside_next;
    logic [7:0]             cwl_reg, cwl_next;
    logic                   ovf_reg, ovf_next;
    logic [15:0]            words_reg, words_next;
    logic [COL_W-1:0]       col_reg, col_next;
    logic [7:0]             diag_reg, diag_next;
    logic [7:0]             left_reg, left_next;
    logic [7:0]             d_reg, d_next;
    logic [7:0]             big_reg, big_next;
    logic [7:0]             diff_reg, diff_next;
    logic [7:0]             rem_reg, rem_next;
    logic [QUO_W-1:0]       quo_reg, quo_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [15:0]            idx_reg, idx_next;
    logic [MAX_REF_LEN-1:0] valid_reg;

    logic                   m_valid_reg, m_valid_next;
    logic [7:0]             out_dist_reg;
    logic [QUO_W-1:0]       out_sim_reg;
    logic [7:0]             out_len_reg;
    logic [15:0]            out_idx_reg;
    logic                   out_sat_reg;
    logic                   out_load;

    // DP row cells 1..MAX_REF_LEN; cell 0 always equals the word length
    logic [7:0]             row_mem [MAX_REF_LEN];
    logic [7:0]             rd_data_reg;
    logic                   rd_hit_reg;
    logic [ADDR_W-1:0]      rd_addr;
    logic [ADDR_W-1:0]      wr_addr;
    logic                   wr_en;

    logic [COL_W-1:0]       n_eff;
    logic [7:0]             n8;
    logic [7:0]             in_byte;
    logic [7:0]             in_norm;
    logic                   in_add;
    logic                   in_space;
    logic                   close_req;
    logic                   accept;
    logic [7:0]             base_len;
    logic [7:0]             new_len;

    logic [7:0]             ref_bytes [REF_BYTES];
    logic [COL_W-1:0]       ref_idx;
    logic [7:0]             ref_b;
    logic [7:0]             up;
    logic [8:0]             up1, left1, sub, best;
    logic                   cell_sat;
    logic [7:0]             cell_val;

    logic [7:0]             close_d;
    logic [7:0]             close_big;
    logic [NUM_W-1:0]       num;
    logic [8:0]             trial;
    logic                   trial_ge;
    logic [8:0]             trial_sub;

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_low_reg  <= '0;
            ref_high_reg <= '0;
            ref_len_reg  <= '0;
            max_dist_reg <= 8'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_REF_LOW:  ref_low_reg  <= cfg_data;
                CFG_REF_HIGH: ref_high_reg <= cfg_data;
                CFG_REF_LEN:  ref_len_reg  <= cfg_data[4:0];
                CFG_MAX_DIST: max_dist_reg <= cfg_data[7:0];
                default:      ;
            endcase
        end
    end

    // Effective reference length, clamped to the row size
    assign n_eff = (int'(ref_len_reg) > MAX_REF_LEN) ? COL_W'(MAX_REF_LEN)
                                                     : COL_W'(ref_len_reg);
    assign n8    = 8'(n_eff);

    // Reference bytes, byte 0 in the low bits of the low register
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            ref_bytes[i]     = ref_low_reg[8*i +: 8];
            ref_bytes[i + 8] = ref_high_reg[8*i +: 8];
        end
    end

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign in_byte   = s_tdata;
    assign in_norm   = normalize_char(in_byte);
    assign in_add    = !in_byte[7] && is_alnum(in_norm);
    assign in_space  = !in_byte[7] && is_space(in_norm);
    assign close_req = in_add ? s_tlast : (inside_reg && (in_space || s_tlast));

    // Word length seen before this character, then after it
    assign base_len  = inside_reg ? cwl_reg : 8'd0;
    assign new_len   = (base_len == 8'hFF) ? 8'hFF : base_len + 8'd1;

    // ------------------------------------------------------------------
    // Shared DP cell unit
    // ------------------------------------------------------------------
    assign up       = rd_hit_reg ? rd_data_reg : 8'(col_reg);
    assign ref_idx  = col_reg - COL_W'(1);
    assign ref_b    = (int'(ref_idx) < REF_BYTES) ? ref_bytes[4'(ref_idx)] : 8'd0;
    assign up1      = {1'b0, up} + 9'd1;
    assign left1    = {1'b0, left_reg} + 9'd1;
    assign sub      = {1'b0, diag_reg} + ((ref_b != char_reg) ? 9'd1 : 9'd0);

    always_comb
    begin
        best = up1;
        if (left1 < best)
        begin
            best = left1;
        end
        if (sub < best)
        begin
            best = sub;
        end
    end

    assign cell_sat = (best >= 9'd255);
    assign cell_val = cell_sat ? 8'hFF : best[7:0];

    // ------------------------------------------------------------------
    // Close decode and divider step
    // ------------------------------------------------------------------
    // Last cell; one never written in this word still holds its column number
    assign close_d   = (n_eff == '0) ? cwl_reg : (rd_hit_reg ? rd_data_reg : n8);
    assign close_big = (cwl_reg > n8) ? cwl_reg : n8;
    assign num       = NUM_W'(SIM_SCALE) * NUM_W'(diff_reg);
    assign trial     = {rem_reg, quo_reg[QUO_W-1]};
    assign trial_ge  = (trial >= {1'b0, big_reg});
    assign trial_sub = trial - {1'b0, big_reg};

    // ------------------------------------------------------------------
    // Row memory access
    // ------------------------------------------------------------------
    always_comb
    begin
        case (state_reg)
            ST_PREP:     rd_addr = '0;
            ST_CELL:     rd_addr = ADDR_W'(col_reg);
            default:     rd_addr = ADDR_W'(n_eff - COL_W'(1));
        endcase
    end

    assign wr_en   = (state_reg == ST_CELL);
    assign wr_addr = ADDR_W'(ref_idx);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem[wr_addr] <= cell_val;
        end
        rd_data_reg <= row_mem[rd_addr];
    end

    // Per-cell valid flags; an invalid cell reads as its column number
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            rd_hit_reg <= (int'(rd_addr) < MAX_REF_LEN) && valid_reg[rd_addr];
            if (accept && in_add && !inside_reg)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next  = state_reg;
        char_next   = char_reg;
        eom_next    = eom_reg;
        close_next  = close_reg;
        inside_next = inside_reg;
        cwl_next    = cwl_reg;
        ovf_next    = ovf_reg;
        words_next  = words_reg;
        col_next    = col_reg;
        diag_next   = diag_reg;
        left_next   = left_reg;
        d_next      = d_reg;
        big_next    = big_reg;
        diff_next   = diff_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        out_load    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    char_next  = in_norm;
                    eom_next   = s_tlast;
                    close_next = close_req;
                    if (in_add)
                    begin
                        cwl_next    = new_len;
                        diag_next   = base_len;
                        left_next   = new_len;
                        ovf_next    = (inside_reg && ovf_reg) || (new_len == 8'hFF);
                        inside_next = 1'b1;
                        if (n_eff != '0)
                        begin
                            state_next = ST_PREP;
                        end
                        else
                        begin
                            state_next = close_req ? ST_CLOSE_RD : ST_FINISH;
                        end
                    end
                    else
                    begin
                        state_next = close_req ? ST_CLOSE_RD : ST_FINISH;
                    end
                end
            end

            ST_PREP:
            begin
                col_next   = COL_W'(1);
                state_next = ST_CELL;
            end

            // One DP cell per cycle
            ST_CELL:
            begin
                left_next = cell_val;
                diag_next = up;
                ovf_next  = ovf_reg || cell_sat;
                if (col_reg == n_eff)
                begin
                    state_next = close_reg ? ST_CLOSE_RD : ST_FINISH;
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end

            ST_CLOSE_RD:
            begin
                state_next = ST_CLOSE_D;
            end

            // Word closes: count it, test the threshold
            ST_CLOSE_D:
            begin
                d_next      = close_d;
                diff_next   = (close_d <= close_big) ? close_big - close_d : 8'd0;
                big_next    = (close_big == 8'd0) ? 8'd1 : close_big;
                idx_next    = words_reg;
                words_next  = (words_reg == 16'hFFFF) ? words_reg : words_reg + 16'd1;
                inside_next = 1'b0;
                state_next  = (close_d <= max_dist_reg) ? ST_MUL : ST_FINISH;
            end

            // Top bits of the numerator are already below the divisor
            ST_MUL:
            begin
                rem_next   = num[NUM_W-1:QUO_W];
                quo_next   = num[QUO_W-1:0];
                cnt_next   = '0;
                state_next = ST_DIV;
            end

            // Restoring division, one quotient bit per cycle
            ST_DIV:
            begin
                rem_next = trial_ge ? trial_sub[7:0] : trial[7:0];
                quo_next = {quo_reg[QUO_W-2:0], trial_ge};
                cnt_next = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(QUO_W - 1))
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (eom_reg)
                begin
                    words_next  = '0;
                    inside_next = 1'b0;
                end
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            inside_reg <= 1'b0;
            cwl_reg    <= '0;
            ovf_reg    <= 1'b0;
            words_reg  <= '0;
            close_reg  <= 1'b0;
            eom_reg    <= 1'b0;
            col_reg    <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            inside_reg <= inside_next;
            cwl_reg    <= cwl_next;
            ovf_reg    <= ovf_next;
            words_reg  <= words_next;
            close_reg  <= close_next;
            eom_reg    <= eom_next;
            col_reg    <= col_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        diag_reg <= diag_next;
        left_reg <= left_next;
        d_reg    <= d_next;
        big_reg  <= big_next;
        diff_reg <= diff_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        idx_reg  <= idx_next;
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_dist_reg <= d_reg;
            out_sim_reg  <= quo_reg;
            out_len_reg  <= cwl_reg;
            out_idx_reg  <= idx_reg;
            out_sat_reg  <= ovf_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, out_idx_reg, out_len_reg, out_sim_reg, out_dist_reg};
    assign m_tuser  = out_sat_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CELL) |-> (col_reg != '0) && (col_reg <= n_eff))
        else $error("DP column outside the reference word");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg < DIV_CNT_W'(QUO_W)))
        else $error("divider ran past its quotient width");

    a_sim_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (int'(quo_reg) <= SIM_SCALE))
        else $error("similarity above full scale");

    a_word_len: assert property (@(posedge clk) disable iff (!rst_n)
        inside_reg |-> (cwl_reg != 8'd0))
        else $error("open word with zero length");

    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!m_valid_reg || m_tready))
        else $error("result loaded over an untaken result");

endmodule

`default_nettype wire
